// File: rtl/running_median_core_macros.svh
// Assertion helpers shared by the running median RTL.
`ifndef RUNNING_MEDIAN_CORE_MACROS_SVH
`define RUNNING_MEDIAN_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rmed_pkg.sv
package rmed_pkg;

  localparam int unsigned MAX_ITEMS = 1024;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               restart;
  } rm_in_t;

  typedef struct packed {
    logic signed [31:0] median;
    logic               full_res;
  } rm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MRD0,
    ST_MRD1,
    ST_MCAP,
    ST_MOUT
  } rm_state_e;

endpackage

// File: rtl/running_median_core.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+---------------------------
// request   | in_valid_i / in_ready_o      | in_data_i  (rmed_pkg::rm_in_t)
// result    | out_valid_o / out_ready_i    | out_data_o (rmed_pkg::rm_out_t)
//
// A request is taken only in the idle state, so each one is through before the next is
// accepted. The insertion walks the sorted memory down, one read and one compare-and-write
// per cell, past each stored sample greater than the new one. A dropped sample (store
// full) skips the insertion and repeats the median. Reset empties the store at
// once through the sample count; the memory itself needs no clearing. A stalled
// result waits in the output register while the next request is taken.
`include "running_median_core_macros.svh"

module running_median_core #(
  parameter int unsigned MaxItems = rmed_pkg::MAX_ITEMS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rmed_pkg::rm_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rmed_pkg::rm_out_t out_data_o
);

  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned CW = $clog2(MaxItems + 1);

  // Sorted sample store: one write port, one registered read port.
  logic signed [31:0] mem [MaxItems];
  logic signed [31:0] rd_q;
  logic               we;
  logic [AW-1:0]      wa;
  logic [AW-1:0]      ra;
  logic signed [31:0] wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  rmed_pkg::rm_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic signed [31:0]  x_q, x_d;
  logic                full_q, full_d;
  logic signed [31:0]  lo_q, lo_d;
  logic signed [31:0]  hi_q, hi_d;
  logic                out_valid_q, out_valid_d;
  rmed_pkg::rm_out_t   out_q, out_d;

  logic [CW-1:0]       eff_cnt;
  logic [CW-1:0]       lo_idx;
  logic [CW-1:0]       hi_idx;
  logic signed [32:0]  pair_sum;
  logic signed [32:0]  pair_half;
  logic signed [31:0]  med_val;
  logic                accept;

  assign accept  = in_valid_i && in_ready_o;
  assign eff_cnt = in_data_i.restart ? '0 : count_q;
  assign lo_idx  = (count_q - CW'(1)) >> 1;
  assign hi_idx  = count_q >> 1;

  // Even count: 33-bit sum, halved with truncation toward zero.
  assign pair_sum  = 33'(lo_q) + 33'(hi_q);
  assign pair_half = (pair_sum >>> 1) + 33'(pair_sum[32] & pair_sum[0]);
  assign med_val   = count_q[0] ? lo_q : pair_half[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmed_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    x_q    <= x_d;
    full_q <= full_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    x_d         = x_q;
    full_d      = full_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    we          = 1'b0;
    wa          = pos_q;
    wd          = x_q;
    ra          = pos_q - AW'(1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rmed_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d = in_data_i.sample;
          if (eff_cnt == CW'(MaxItems)) begin
            // Store full: keep the contents and repeat the median.
            full_d  = 1'b1;
            count_d = eff_cnt;
            state_d = rmed_pkg::ST_MRD0;
          end else begin
            full_d  = 1'b0;
            pos_d   = eff_cnt[AW-1:0];
            count_d = eff_cnt + CW'(1);
            state_d = rmed_pkg::ST_RD;
          end
        end
      end
      rmed_pkg::ST_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = rmed_pkg::ST_MRD0;
        end else begin
          state_d = rmed_pkg::ST_CMP;
        end
      end
      rmed_pkg::ST_CMP: begin
        we = 1'b1;
        if (rd_q > x_q) begin
          // Larger neighbor moves up one cell; keep walking down.
          wd      = rd_q;
          pos_d   = pos_q - AW'(1);
          state_d = rmed_pkg::ST_RD;
        end else begin
          state_d = rmed_pkg::ST_MRD0;
        end
      end
      rmed_pkg::ST_MRD0: begin
        ra      = lo_idx[AW-1:0];
        state_d = rmed_pkg::ST_MRD1;
      end
      rmed_pkg::ST_MRD1: begin
        ra      = hi_idx[AW-1:0];
        lo_d    = rd_q;
        state_d = rmed_pkg::ST_MCAP;
      end
      rmed_pkg::ST_MCAP: begin
        hi_d    = rd_q;
        state_d = rmed_pkg::ST_MOUT;
      end
      rmed_pkg::ST_MOUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.median   = med_val;
          out_d.full_res = full_q;
          out_valid_d    = 1'b1;
          state_d        = rmed_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmed_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RMC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MaxItems), "sample count overflow")
  `RMC_ASSERT_NEXT(a_busy_after_accept, accept, state_q != rmed_pkg::ST_IDLE, "accept not taken")
  `RMC_ASSERT_NOW(a_write_in_range, we, CW'(wa) < count_q, "write beyond stored samples")

endmodule
